// ===== hdl/spe_pkg.sv =====
package spe_pkg;

   localparam int MAX_ITEMS_DEF = 16;
   localparam int WORD_BITS     = 16;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] value;
      logic                        last;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] result_value;
      logic                        result_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_NEG,
      ST_FIND_POS,
      ST_SWAP_RD,
      ST_SWAP_WR_A,
      ST_SWAP_WR_B,
      ST_EMIT
   } spe_state_type;

   typedef struct packed {
      logic load;       // store the input beat
      logic begin_set;  // clear pass and emit counters
      logic find_neg;
      logic find_pos;
      logic swap_rd;
      logic swap_wr_a;
      logic swap_wr_b;
      logic pass_inc;
      logic emit;
   } spe_cmd_type;

   typedef struct packed {
      logic neg_found;
      logic pos_found;
      logic pass_done;
      logic emit_done;
   } spe_status_type;

endpackage

// ===== hdl/spe_datapath.sv =====
module spe_datapath #(
   parameter int MAX_ITEMS = spe_pkg::MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spe_pkg::req_payload_type req_payload,
   input  spe_pkg::spe_cmd_type     cmd,
   output spe_pkg::spe_status_type  status,
   output logic                     rsp_strobe,
   output spe_pkg::rsp_payload_type rsp_payload
);
   import spe_pkg::*;

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [WORD_BITS-1:0] mem [MAX_ITEMS];
   logic [WORD_BITS-1:0] rd_a_ff, rd_b_ff;

   logic [MAX_ITEMS-1:0] neg_ff, pos_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        pass_ff, pass_in;
   logic [CW-1:0]        emit_ff, emit_in;
   logic [IW-1:0]        neg_idx_ff, pos_idx_ff;
   logic                 strobe_ff, strobe_in;
   logic                 last_ff;

   logic [MAX_ITEMS-1:0] in_set, below_neg;
   logic [IW-1:0]        neg_idx_in, pos_idx_in;
   logic                 neg_hit, pos_hit;
   logic                 room;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr, rd_a_addr;
   logic [WORD_BITS-1:0] wr_data, in_word;

   assign in_word = req_payload.value;
   assign room    = count_ff < CW'(MAX_ITEMS);

   // highest negative in the set, lowest positive below it
   always_comb begin
      neg_idx_in = '0;
      neg_hit    = 1'b0;
      pos_idx_in = '0;
      pos_hit    = 1'b0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         in_set[i]    = CW'(i) < count_ff;
         below_neg[i] = IW'(i) < neg_idx_ff;
      end
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (neg_ff[i] && in_set[i]) begin
            neg_idx_in = IW'(i);
            neg_hit    = 1'b1;
         end
      end
      for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
         if (pos_ff[i] && below_neg[i]) begin
            pos_idx_in = IW'(i);
            pos_hit    = 1'b1;
         end
      end
   end

   assign status.neg_found = neg_hit;
   assign status.pos_found = pos_hit;
   assign status.pass_done = pass_ff == count_ff - 1'b1;
   assign status.emit_done = emit_ff == count_ff - 1'b1;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_data = in_word;
      if (cmd.load && room) begin
         wr_en = 1'b1;
      end else if (cmd.swap_wr_a) begin
         wr_en   = 1'b1;
         wr_addr = pos_idx_ff;
         wr_data = rd_b_ff;
      end else if (cmd.swap_wr_b) begin
         wr_en   = 1'b1;
         wr_addr = neg_idx_ff;
         wr_data = rd_a_ff;
      end
      rd_a_addr = cmd.swap_rd ? pos_idx_ff : emit_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.swap_rd || cmd.emit) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (cmd.swap_rd) begin
         rd_b_ff <= mem[neg_idx_ff];
      end
   end

   // sign flags follow the words; a swap moves a negative down, a positive up
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         neg_ff[count_ff[IW-1:0]] <= in_word[WORD_BITS-1];
         pos_ff[count_ff[IW-1:0]] <= !in_word[WORD_BITS-1] && (in_word != '0);
      end else if (cmd.swap_rd) begin
         neg_ff[pos_idx_ff] <= 1'b1;
         pos_ff[pos_idx_ff] <= 1'b0;
         neg_ff[neg_idx_ff] <= 1'b0;
         pos_ff[neg_idx_ff] <= 1'b1;
      end
      if (cmd.find_neg) begin
         neg_idx_ff <= neg_idx_in;
      end
      if (cmd.find_pos) begin
         pos_idx_ff <= pos_idx_in;
      end
      if (cmd.emit) begin
         last_ff <= status.emit_done;
      end
   end

   always_comb begin
      count_in  = count_ff;
      pass_in   = pass_ff;
      emit_in   = emit_ff;
      strobe_in = cmd.emit;
      if (cmd.load && room) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.begin_set) begin
         pass_in = '0;
         emit_in = '0;
      end
      if (cmd.pass_inc) begin
         pass_in = pass_ff + 1'b1;
      end
      if (cmd.emit) begin
         emit_in = emit_ff + 1'b1;
         if (status.emit_done) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pass_ff   <= '0;
         emit_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pass_ff   <= pass_in;
         emit_ff   <= emit_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_payload.result_value = $signed(rd_a_ff);
   assign rsp_payload.result_last  = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("load count beyond capacity");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.swap_rd |-> neg_ff[neg_idx_ff] && pos_ff[pos_idx_ff] && pos_idx_ff < neg_idx_ff)
      else $error("swap without a positive before a negative");

   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.result_last |-> count_ff == '0)
      else $error("set not cleared after final beat");

endmodule

// ===== hdl/spe_controller.sv =====
module spe_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_last,
   input  spe_pkg::spe_status_type status,
   output spe_pkg::spe_cmd_type    cmd,
   output logic                    busy
);
   import spe_pkg::*;

   spe_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a pass that swaps nothing leaves the set as is, so later passes are skipped
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.begin_set = 1'b1;
                  state_in      = ST_FIND_NEG;
               end
            end
         end
         ST_FIND_NEG: begin
            cmd.find_neg = 1'b1;
            state_in     = status.neg_found ? ST_FIND_POS : ST_EMIT;
         end
         ST_FIND_POS: begin
            cmd.find_pos = 1'b1;
            state_in     = status.pos_found ? ST_SWAP_RD : ST_EMIT;
         end
         ST_SWAP_RD: begin
            cmd.swap_rd = 1'b1;
            state_in    = ST_SWAP_WR_A;
         end
         ST_SWAP_WR_A: begin
            cmd.swap_wr_a = 1'b1;
            state_in      = ST_SWAP_WR_B;
         end
         ST_SWAP_WR_B: begin
            cmd.swap_wr_b = 1'b1;
            if (status.pass_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.pass_inc = 1'b1;
               state_in     = ST_FIND_NEG;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_pos_after_neg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND_POS |-> $past(state_ff) == ST_FIND_NEG)
      else $error("positive search not preceded by negative search");

   a_swap_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP_RD |=> state_ff == ST_SWAP_WR_A ##1 state_ff == ST_SWAP_WR_B)
      else $error("swap sequence broken");

   a_idle_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.emit_done |=> !busy)
      else $error("not idle after final beat");

endmodule

// ===== hdl/sign_partition_engine_unit.sv =====
// Sign partition engine.
// Input: a beat is taken when start is high and busy is low. Each beat
// carries one signed word; words go into a store of MAX_ITEMS entries, and
// words beyond capacity are dropped. A beat with last set closes the set.
// After a last beat the block goes busy and runs up to n passes over the
// n stored words: each pass finds the highest negative and the lowest
// positive below it and exchanges them; zeros stay put. A pass runs two
// searches, one read and two writes through the single write port of the
// store; the first pass that finds no pair ends the rearrangement.
// Results: the words come out in index order, one per cycle, each valid for
// the single cycle rsp_strobe is high; result_last marks the final one.
// A set is loaded, then rearranged, then output; the first result follows
// the rearrangement. busy falls on the cycle the final result is shown.
// The receiver cannot stall; results are not held.
// Reset clears the set count and the controller; store contents need none.
module sign_partition_engine_unit #(
   parameter int MAX_ITEMS = spe_pkg::MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  spe_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output spe_pkg::rsp_payload_type rsp_payload
);
   import spe_pkg::*;

   spe_cmd_type    cmd;
   spe_status_type status;

   spe_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_payload.last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   spe_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/sign_partition_checker.sv =====
module sign_partition_checker #(
   parameter int MAX_ITEMS = spe_pkg::MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  spe_pkg::req_payload_type req_payload,
   input  logic                     rsp_strobe,
   input  spe_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import spe_pkg::*;

   logic [WORD_BITS-1:0] held_words [MAX_ITEMS];
   int                   held_count = 0;
   rsp_payload_type      expected_words [$];
   rsp_payload_type      oldest;
   int                   mismatches = 0;
   int                   queued = 0;

   assign error_count   = mismatches;
   assign pending_words = queued;

   // n passes over the held set, then one expected beat per held word
   task automatic partition_and_queue();
      int                   n;
      int                   neg_idx;
      int                   pos_idx;
      logic [WORD_BITS-1:0] tmp;
      rsp_payload_type      word_out;
      n = held_count;
      for (int pass = 0; pass < n; pass++) begin
         neg_idx = -1;
         pos_idx = -1;
         for (int i = n - 1; i >= 0; i--)
            if (neg_idx < 0 && held_words[i][WORD_BITS-1]) neg_idx = i;
         for (int i = 0; i < neg_idx; i++)
            if (pos_idx < 0 && held_words[i] != '0 && !held_words[i][WORD_BITS-1])
               pos_idx = i;
         if (pos_idx >= 0) begin
            tmp                 = held_words[pos_idx];
            held_words[pos_idx] = held_words[neg_idx];
            held_words[neg_idx] = tmp;
         end
      end
      for (int k = 0; k < n; k++) begin
         word_out.result_value = held_words[k];
         word_out.result_last  = (k == n - 1);
         expected_words.push_back(word_out);
      end
      held_count = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result beat: result_value %0d result_last %0b",
                      $signed(rsp_payload.result_value), rsp_payload.result_last);
               mismatches++;
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_payload.result_value !== oldest.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         $signed(oldest.result_value), $signed(rsp_payload.result_value));
                  mismatches++;
               end
               if (rsp_payload.result_last !== oldest.result_last) begin
                  $error("result_last: expected %0b, got %0b",
                         oldest.result_last, rsp_payload.result_last);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            // full store drops the word, a dropped last still closes the set
            if (held_count < MAX_ITEMS) begin
               held_words[held_count] = req_payload.value;
               held_count++;
            end
            if (req_payload.last) partition_and_queue();
         end
      end
      queued = expected_words.size();
   end

endmodule

// ===== sim/tb_sign_partition_engine_unit.sv =====
module tb_sign_partition_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import spe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 480;
   localparam int PAYLOAD_BITS   = $bits(req_payload_type);

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;
   int              error_count;
   int              pending_words;
   int              quiet_cycles = 0;

   always #2 clock = ~clock;

   sign_partition_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   sign_partition_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sign_partition_engine_unit NOT OK");
            $finish;
         end
      end
   end

   function automatic int idle_gap(input int pct);
      int g;
      g = 0;
      while (g < 60 && $urandom_range(99) < pct) g++;
      return g;
   endfunction

   // bias: 0 mixed, 1 mostly positive, 2 mostly negative, 3 zero heavy
   function automatic logic [WORD_BITS-1:0] random_word(input int bias);
      logic [WORD_BITS-1:0] w;
      w = WORD_BITS'($urandom);
      case (bias)
         1: w[WORD_BITS-1] = ($urandom_range(9) == 0);
         2: w[WORD_BITS-1] = ($urandom_range(9) != 0);
         3: if ($urandom_range(1) == 1) w = '0;
         default: ;
      endcase
      case ($urandom_range(11))
         0: w = '0;
         1: w = {1'b0, {(WORD_BITS-1){1'b1}}};
         2: w = {1'b1, {(WORD_BITS-1){1'b0}}};
         3: w = '1;
         4: w = WORD_BITS'(1);
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_beat(input logic [WORD_BITS-1:0] value, input logic last,
                            input int gap);
      req_payload_type         beat;
      logic [PAYLOAD_BITS-1:0] noise;
      repeat (gap) begin
         @(negedge clock);
         noise = PAYLOAD_BITS'($urandom);
         start       <= 1'b0;
         req_payload <= noise;
      end
      beat.value = value;
      beat.last  = last;
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   initial begin
      int beats_sent;
      int set_len;
      int bias;
      int pct;
      int r;
      start       = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, zero and both signs in one set
      send_beat({1'b0, {(WORD_BITS-1){1'b1}}}, 1'b0, 0);
      send_beat({1'b1, {(WORD_BITS-1){1'b0}}}, 1'b0, 0);
      send_beat('0, 1'b0, 0);
      send_beat('1, 1'b0, 0);
      send_beat(WORD_BITS'(1), 1'b1, 0);
      // one-word sets
      send_beat('0, 1'b1, 0);
      send_beat(WORD_BITS'(-5), 1'b1, 0);
      // store overflow: the last beat itself is dropped
      for (int i = 0; i < MAX_ITEMS_DEF + 2; i++)
         send_beat(random_word(0), i == MAX_ITEMS_DEF + 1, 0);
      wait_drained();

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         pct = (beats_sent < RANDOM_BEATS / 3) ? 35 :
               (beats_sent < 2 * RANDOM_BEATS / 3) ? 87 : 0;
         if ($urandom_range(5) == 0) pct = 0;
         r = $urandom_range(99);
         if (r < 60)      set_len = $urandom_range(6, 1);
         else if (r < 85) set_len = $urandom_range(MAX_ITEMS_DEF - 1, 7);
         else if (r < 95) set_len = MAX_ITEMS_DEF;
         else             set_len = $urandom_range(MAX_ITEMS_DEF + 4, MAX_ITEMS_DEF + 1);
         bias = $urandom_range(3);
         for (int i = 0; i < set_len; i++)
            send_beat(random_word(bias), i == set_len - 1, idle_gap(pct));
         beats_sent += set_len;
         if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();
      repeat (100) @(posedge clock);

      if (error_count == 0 && pending_words == 0) begin
         $display("tb_sign_partition_engine_unit OK");
      end else begin
         $display("tb_sign_partition_engine_unit NOT OK");
      end
      $finish;
   end

endmodule
